// ===== rtl/hsvrgb_pkg.sv =====
// Package for the HSV to RGB converter: fixed-point constants, the hue
// sector type and the pipeline control struct. It depends on nothing.
package hsvrgb_pkg;

	localparam int HUE_W        = 13;
	localparam int SV_W         = 9;
	localparam int CH_W         = 9;
	localparam int Q_ONE        = 256;
	localparam int SECTOR_UNITS = 960;
	localparam int MAX_SECTOR   = ((1 << HUE_W) - 1) / SECTOR_UNITS;
	localparam int REM_W        = 10;
	localparam int FRAC_W       = 8;
	localparam int FRAC_RECIP   = 4370;
	localparam int RECIP_SHIFT  = 16;
	localparam int NUM_STAGES   = 5;

	typedef enum logic [2:0] {
		SECT_0 = 3'd0,
		SECT_1 = 3'd1,
		SECT_2 = 3'd2,
		SECT_3 = 3'd3,
		SECT_4 = 3'd4,
		SECT_5 = 3'd5
	} sector_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic                  in_ready;
		logic                  out_valid;
	} pipe_ctrl_t;

endpackage

// ===== rtl/hsvrgb_if.sv =====
// Channel interfaces of the HSV to RGB converter: the HSV input beat and the
// RGB result beat, each with valid and ready. They depend on hsvrgb_pkg.
interface hsvrgb_hsv_if;
	import hsvrgb_pkg::*;
	logic               valid;
	logic               ready;
	logic [HUE_W-1:0]   hue;
	logic [SV_W-1:0]    sat_val;
	modport source(output valid, hue, sat_val, input ready);
	modport sink(input valid, hue, sat_val, output ready);
endinterface

interface hsvrgb_rgb_if;
	import hsvrgb_pkg::*;
	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    red;
	logic [CH_W-1:0]    green;
	logic [CH_W-1:0]    blue;
	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hsvrgb_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the converter pipeline.
// Depends on hsvrgb_pkg; a stage loads when it is empty or its successor loads.
module hsvrgb_pipe_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    out_ready,
	output hsvrgb_pkg::pipe_ctrl_t  ctrl
);
	import hsvrgb_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] ld;

	always_comb begin
		ld[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctrl.load      = ld;
	assign ctrl.in_ready  = ld[0];
	assign ctrl.out_valid = vld_q[NUM_STAGES-1];

endmodule

// ===== rtl/hsv_to_rgb_combined_sv_core.sv =====
// Top level of the HSV to RGB converter with a combined saturation/value
// control. Depends on hsvrgb_pkg, hsvrgb_if and hsvrgb_pipe_ctrl.
//
// Usage: an input beat on the hsv channel carries a hue in sixteenths of a
// degree and a combined saturation/value control in Q8. For each input beat
// exactly one beat leaves on the rgb channel with the red, green and blue
// intensities in Q8, in the order the inputs were taken.
// The datapath is a five-stage pipeline: sector and control decode, the
// sector fraction, the saturation products, the value products and the
// channel selection. One beat per cycle is sustained while the receiver is
// ready; a receiver stall holds the flow, as described below.
// Reset clears every stage valid bit, so no result is presented until new
// input beats arrive. When the receiver stalls, the last stage holds its
// result and earlier stages keep filling any empty slots, so input beats are
// still taken until all five stages are occupied; nothing is lost or
// repeated.
module hsv_to_rgb_combined_sv_core (
	input  logic                clk,
	input  logic                arst_n,
	hsvrgb_hsv_if.sink          hsv,
	hsvrgb_rgb_if.source        rgb
);
	import hsvrgb_pkg::*;

	pipe_ctrl_t ctrl;

	hsvrgb_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv.valid),
		.out_ready (rgb.ready),
		.ctrl      (ctrl)
	);

	assign hsv.ready = ctrl.in_ready;
	assign rgb.valid = ctrl.out_valid;

	// Stage 1: control mapping and hue sector.
	logic [SV_W-1:0]   sv_c;
	logic [CH_W-1:0]   s_n;
	logic [CH_W-1:0]   v_n;
	logic [3:0]        sec_cnt;
	logic [HUE_W-1:0]  sec_base;
	sector_t           sec_n;
	logic [CH_W-1:0]   s_s1;
	logic [CH_W-1:0]   v_s1;
	sector_t           sec_s1;
	logic [REM_W-1:0]  rem_s1;

	always_comb begin
		sv_c = (hsv.sat_val > SV_W'(Q_ONE)) ? SV_W'(Q_ONE) : hsv.sat_val;
		if (sv_c >= SV_W'(Q_ONE / 2)) begin
			s_n = CH_W'((SV_W + 1)'(2 * Q_ONE) - {sv_c, 1'b0});
			v_n = CH_W'(Q_ONE);
		end else begin
			s_n = CH_W'(Q_ONE);
			v_n = {sv_c[CH_W-2:0], 1'b0};
		end
		sec_cnt = '0;
		for (int k = 1; k <= MAX_SECTOR; k++) begin
			if (hsv.hue >= HUE_W'(k * SECTOR_UNITS)) begin
				sec_cnt = 4'(k);
			end
		end
		sec_base = HUE_W'(sec_cnt * SECTOR_UNITS);
		if (sec_cnt <= 4'(SECT_5)) begin
			sec_n = sector_t'(sec_cnt[2:0]);
		end else begin
			sec_n = SECT_0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			s_s1   <= s_n;
			v_s1   <= v_n;
			sec_s1 <= sec_n;
			rem_s1 <= REM_W'(hsv.hue - sec_base);
		end
	end

	// Stage 2: fraction within the sector, rem * 256 / 960 by reciprocal.
	logic [23:0]       f_prod;
	logic [CH_W-1:0]   s_s2;
	logic [CH_W-1:0]   v_s2;
	sector_t           sec_s2;
	logic [FRAC_W-1:0] f_s2;

	assign f_prod = 24'({rem_s1, 2'b00}) * 24'(FRAC_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			s_s2   <= s_s1;
			v_s2   <= v_s1;
			sec_s2 <= sec_s1;
			f_s2   <= f_prod[RECIP_SHIFT +: FRAC_W];
		end
	end

	// Stage 3: saturation scaled by the fraction and its complement.
	logic [CH_W-1:0]   fc;
	logic [16:0]       sf_prod;
	logic [16:0]       sg_prod;
	logic [CH_W-1:0]   sf_s3;
	logic [CH_W-1:0]   sg_s3;
	logic [CH_W-1:0]   p_s3;
	logic [CH_W-1:0]   v_s3;
	sector_t           sec_s3;

	assign fc      = CH_W'(Q_ONE) - CH_W'(f_s2);
	assign sf_prod = 17'(s_s2) * 17'(f_s2);
	assign sg_prod = 17'(s_s2) * 17'(fc);

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			sf_s3  <= sf_prod[16:8];
			sg_s3  <= sg_prod[16:8];
			p_s3   <= CH_W'(Q_ONE) - s_s2;
			v_s3   <= v_s2;
			sec_s3 <= sec_s2;
		end
	end

	// Stage 4: value times each of the factors p, q and t.
	logic [CH_W-1:0]   q_f;
	logic [CH_W-1:0]   t_f;
	logic [16:0]       vp_prod;
	logic [16:0]       vq_prod;
	logic [16:0]       vt_prod;
	logic [CH_W-1:0]   vp_s4;
	logic [CH_W-1:0]   vq_s4;
	logic [CH_W-1:0]   vt_s4;
	logic [CH_W-1:0]   v_s4;
	sector_t           sec_s4;

	assign q_f     = CH_W'(Q_ONE) - sf_s3;
	assign t_f     = CH_W'(Q_ONE) - sg_s3;
	assign vp_prod = 17'(v_s3) * 17'(p_s3);
	assign vq_prod = 17'(v_s3) * 17'(q_f);
	assign vt_prod = 17'(v_s3) * 17'(t_f);

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			vp_s4  <= vp_prod[16:8];
			vq_s4  <= vq_prod[16:8];
			vt_s4  <= vt_prod[16:8];
			v_s4   <= v_s3;
			sec_s4 <= sec_s3;
		end
	end

	// Stage 5: channel assignment by sector.
	logic [CH_W-1:0] red_n;
	logic [CH_W-1:0] green_n;
	logic [CH_W-1:0] blue_n;
	logic [CH_W-1:0] red_s5;
	logic [CH_W-1:0] green_s5;
	logic [CH_W-1:0] blue_s5;

	always_comb begin
		case (sec_s4)
			SECT_1: begin
				red_n = vq_s4; green_n = v_s4; blue_n = vp_s4;
			end
			SECT_2: begin
				red_n = vp_s4; green_n = v_s4; blue_n = vt_s4;
			end
			SECT_3: begin
				red_n = vp_s4; green_n = vq_s4; blue_n = v_s4;
			end
			SECT_4: begin
				red_n = vt_s4; green_n = vp_s4; blue_n = v_s4;
			end
			SECT_5: begin
				red_n = v_s4; green_n = vp_s4; blue_n = vq_s4;
			end
			default: begin
				red_n = v_s4; green_n = vt_s4; blue_n = vp_s4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			red_s5   <= red_n;
			green_s5 <= green_n;
			blue_s5  <= blue_n;
		end
	end

	assign rgb.red   = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue  = blue_s5;

	// The input is refused only when the whole pipeline is full and stalled.
	a_full_when_refused: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv.ready |-> (rgb.valid && !rgb.ready))
		else $error("input refused while the pipeline has room");

	// No channel of a result exceeds full intensity.
	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		rgb.valid |-> (rgb.red <= CH_W'(Q_ONE) && rgb.green <= CH_W'(Q_ONE)
			&& rgb.blue <= CH_W'(Q_ONE)))
		else $error("result channel above full intensity");

	// Each value product stays at or below the value itself.
	a_products_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load[4] |-> (vp_s4 <= v_s4 && vq_s4 <= v_s4 && vt_s4 <= v_s4))
		else $error("value product above the value");

endmodule

// ===== dv/hsvrgb_colour_checker.sv =====
`timescale 1ns / 1ps
// Watches the hsv and rgb channels of the HSV to RGB converter, works out the
// colour for every accepted hsv beat and checks the rgb beats in order.
// Depends on hsvrgb_pkg and hsvrgb_if.
module hsvrgb_colour_checker (
	input  logic    clk,
	input  logic    arst_n,
	hsvrgb_hsv_if   hsv,
	hsvrgb_rgb_if   rgb,
	output int      fails,
	output int      outstanding
);
	import hsvrgb_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} colour_t;

	colour_t pending_colours [$];
	int      mismatch_total = 0;

	function automatic logic [CH_W-1:0] q8_scale(int unsigned a, int unsigned b);
		int unsigned prod;
		prod = (a * b) >> 8;
		return prod[CH_W-1:0];
	endfunction

	function automatic colour_t hsv_to_colour(logic [HUE_W-1:0] hue,
						  logic [SV_W-1:0] sat_val);
		int unsigned sv, s, v, sect, rem, f, p, q, t;
		colour_t     c;
		sv = sat_val;
		if (sv > Q_ONE)
			sv = Q_ONE;
		if (sv >= Q_ONE / 2) begin
			s = 2 * Q_ONE - 2 * sv;
			v = Q_ONE;
		end else begin
			s = Q_ONE;
			v = 2 * sv;
		end
		c.red   = v[CH_W-1:0];
		c.green = v[CH_W-1:0];
		c.blue  = v[CH_W-1:0];
		if (s != 0) begin
			sect = hue / SECTOR_UNITS;
			rem  = hue % SECTOR_UNITS;
			f    = (rem * Q_ONE) / SECTOR_UNITS;
			p    = Q_ONE - s;
			q    = Q_ONE - ((s * f) >> 8);
			t    = Q_ONE - ((s * (Q_ONE - f)) >> 8);
			// A hue of 360 degrees or more falls through to the first sector's formulas.
			case (sect)
				SECT_1: begin
					c.red  = q8_scale(v, q);
					c.blue = q8_scale(v, p);
				end
				SECT_2: begin
					c.red  = q8_scale(v, p);
					c.blue = q8_scale(v, t);
				end
				SECT_3: begin
					c.red   = q8_scale(v, p);
					c.green = q8_scale(v, q);
				end
				SECT_4: begin
					c.red   = q8_scale(v, t);
					c.green = q8_scale(v, p);
				end
				SECT_5: begin
					c.green = q8_scale(v, p);
					c.blue  = q8_scale(v, q);
				end
				default: begin
					c.green = q8_scale(v, t);
					c.blue  = q8_scale(v, p);
				end
			endcase
		end
		return c;
	endfunction

	task automatic check_channel(string what, logic [CH_W-1:0] exp_val,
				     logic [CH_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, exp_val, act_val);
			mismatch_total++;
		end
	endtask

	always @(posedge clk) begin
		colour_t want;
		if (!arst_n) begin
			fails       <= 0;
			outstanding <= 0;
		end else begin
			if (hsv.valid && hsv.ready)
				pending_colours.push_back(hsv_to_colour(hsv.hue, hsv.sat_val));
			if (rgb.valid && rgb.ready) begin
				if (pending_colours.size() == 0) begin
					$display("%0t: rgb beat expected none actual %0d/%0d/%0d", $time,
						 rgb.red, rgb.green, rgb.blue);
					mismatch_total++;
				end else begin
					want = pending_colours.pop_front();
					check_channel("red", want.red, rgb.red);
					check_channel("green", want.green, rgb.green);
					check_channel("blue", want.blue, rgb.blue);
				end
			end
			fails       <= mismatch_total;
			outstanding <= pending_colours.size();
		end
	end

endmodule

// ===== dv/tb_hsv_to_rgb_combined_sv_core.sv =====
`timescale 1ns / 1ps
// Top of the HSV to RGB converter testbench: clock, reset, hsv beats and rgb
// back-pressure, with the verdict. Depends on hsvrgb_pkg, hsvrgb_if, the core
// and hsvrgb_colour_checker.
module tb_hsv_to_rgb_combined_sv_core;
	import hsvrgb_pkg::*;

	localparam int RANDOM_BEATS = 700;
	localparam int QUIET_BEATS  = 100;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   outstanding;
	int   cycle_count = 0;
	int   tx_gap_pct = 0;
	int   rx_stall_pct = 0;

	int unsigned corner_hue [24] = '{0, 0, 0, 959, 960, 1919, 1920, 2879, 2880, 3840,
		4799, 4800, 5759, 5760, 5760, 6720, 8191, 8191, 480, 2400, 1000, 3000, 4000, 7000};
	int unsigned corner_sv  [24] = '{0, 256, 128, 128, 128, 64, 192, 127, 129, 1,
		255, 200, 128, 128, 64, 128, 128, 511, 257, 511, 256, 255, 0, 300};

	hsvrgb_hsv_if hsv_ch ();
	hsvrgb_rgb_if rgb_ch ();

	hsv_to_rgb_combined_sv_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	hsvrgb_colour_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.hsv         (hsv_ch),
		.rgb         (rgb_ch),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_hsv(input int unsigned h, input int unsigned sv);
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			hsv_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		hsv_ch.valid   <= 1'b1;
		hsv_ch.hue     <= h[HUE_W-1:0];
		hsv_ch.sat_val <= sv[SV_W-1:0];
		do @(negedge clk); while (!hsv_ch.ready);
		@(posedge clk);
	endtask

	task automatic drain_colours();
		hsv_ch.valid <= 1'b0;
		@(negedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin
		int unsigned burst;
		burst = 0;
		rgb_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (burst == 0 && rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
				burst = $urandom_range(1, 5);
			if (burst != 0) begin
				rgb_ch.ready <= 1'b0;
				burst--;
			end else begin
				rgb_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned h, sv, pick;
		hsv_ch.valid   <= 1'b0;
		hsv_ch.hue     <= '0;
		hsv_ch.sat_val <= '0;
		arst_n         <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_gap_pct   = 30;
		rx_stall_pct = 30;
		foreach (corner_hue[i])
			send_hsv(corner_hue[i], corner_sv[i]);
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 50 == 0) begin
				tx_gap_pct   = $urandom_range(0, 2) * 25;
				rx_stall_pct = $urandom_range(0, 2) * 25;
			end
			if (n == RANDOM_BEATS / 2)
				drain_colours();
			if (n >= RANDOM_BEATS - QUIET_BEATS) begin
				tx_gap_pct   = 0;
				rx_stall_pct = 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				h  = $urandom_range(0, 5760);
				sv = $urandom_range(0, 256);
			end else if (pick < 85) begin
				h  = $urandom_range(0, 6) * SECTOR_UNITS;
				h  = h + ($urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 1 : 959));
				sv = $urandom_range(0, 1) ? $urandom_range(126, 130) : $urandom_range(0, 256);
			end else begin
				h  = $urandom_range(0, 8191);
				sv = $urandom_range(0, 511);
			end
			send_hsv(h, sv);
		end
		drain_colours();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
